/* rtl/oakt_pkg.sv */
// oakt_pkg: shared types and constants of the open-addressed key table
// used by every module of the block except the generic oakt_ram, no dependencies
package oakt_pkg;

	// table size, must be a power of two
	localparam int SLOTS    = 1024;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 8;
	localparam int CMD_W    = 2;
	localparam int ENTRY_W  = KEY_W + VAL_W;
	localparam int FULL_AT  = (3 * SLOTS + 3) / 4 - 1;

	localparam int IN_W     = 80;
	localparam int OUT_W    = 24;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [63:0] MIX_MULT  = 64'hff51afd7ed558ccd;
	localparam int          MIX_SHIFT = 33;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_LOOKUP,
		OP_CLEAR,
		OP_BADKEY,
		OP_NOP
	} op_kind_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_BADKEY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_CLEAR,
		BK_PROBE,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] home;
	} q_entry_t;

	typedef struct packed {
		logic             found;
		logic             inserted;
		logic [VAL_W-1:0] value_out;
		status_t          status;
	} result_t;

endpackage

/* rtl/oakt_ram.sv */
// oakt_ram: generic single-write, single-read ram with registered read
// no dependencies
module oakt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/oakt_front.sv */
// oakt_front: accepts input words, classifies them and computes the home slot
// two stages: mix multiply partial products, then sum and fold; uses oakt_pkg
module oakt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 init_busy,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [oakt_pkg::IN_W-1:0] s_tdata, // cmd[1:0], key[65:2], value[73:66], zero pad
	input  logic                 q_full,
	output logic                 q_push,
	output oakt_pkg::q_entry_t   q_entry
);

	logic                           v_s1;
	logic [oakt_pkg::CMD_W-1:0]     cmd_s1;
	logic [oakt_pkg::KEY_W-1:0]     key_s1;
	logic [oakt_pkg::VAL_W-1:0]     value_s1;

	logic                           v_s2;
	oakt_pkg::op_kind_t             kind_s2;
	logic [oakt_pkg::KEY_W-1:0]     key_s2;
	logic [oakt_pkg::VAL_W-1:0]     value_s2;
	logic [63:0]                    p_ll_s2;
	logic [31:0]                    p_hl_s2;
	logic [31:0]                    p_lh_s2;

	logic                           adv1;
	logic                           adv2;
	logic                           take;
	oakt_pkg::op_kind_t             kind_c;
	logic [63:0]                    k1;
	logic [63:0]                    p_ll;
	logic [31:0]                    p_hl;
	logic [31:0]                    p_lh;
	logic [31:0]                    mid;
	logic [63:0]                    k2;

	localparam logic [31:0] MULT_LO = oakt_pkg::MIX_MULT[31:0];
	localparam logic [31:0] MULT_HI = oakt_pkg::MIX_MULT[63:32];

	assign adv2     = v_s2 & ~q_full;
	assign adv1     = v_s1 & (~v_s2 | adv2);
	assign s_tready = ~init_busy & (~v_s1 | adv1);
	assign take     = s_tvalid & s_tready;

	// classify
	always_comb begin
		case (cmd_s1)
			oakt_pkg::CMD_INSERT: kind_c = (key_s1 == '0) ? oakt_pkg::OP_BADKEY
				: oakt_pkg::OP_INSERT;
			oakt_pkg::CMD_LOOKUP: kind_c = (key_s1 == '0) ? oakt_pkg::OP_BADKEY
				: oakt_pkg::OP_LOOKUP;
			oakt_pkg::CMD_CLEAR:  kind_c = oakt_pkg::OP_CLEAR;
			default:              kind_c = oakt_pkg::OP_NOP;
		endcase
	end

	// first xor-shift and partial products of the mix multiply
	assign k1   = key_s1 ^ (key_s1 >> oakt_pkg::MIX_SHIFT);
	assign p_ll = 64'(k1[31:0]) * 64'(MULT_LO);
	assign p_hl = 32'(k1[63:32] * MULT_LO);
	assign p_lh = 32'(k1[31:0] * MULT_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1   <= s_tdata[1:0];
			key_s1   <= s_tdata[65:2];
			value_s1 <= s_tdata[73:66];
		end
		if (adv1) begin
			kind_s2  <= kind_c;
			key_s2   <= key_s1;
			value_s2 <= value_s1;
			p_ll_s2  <= p_ll;
			p_hl_s2  <= p_hl;
			p_lh_s2  <= p_lh;
		end
	end

	// low word of the product, then second xor-shift folded to the slot index
	assign mid = p_hl_s2 + p_lh_s2;
	assign k2  = p_ll_s2 + {mid, 32'd0};

	assign q_push        = adv2;
	assign q_entry.kind  = kind_s2;
	assign q_entry.key   = key_s2;
	assign q_entry.value = value_s2;
	assign q_entry.home  = k2[oakt_pkg::SLOT_W-1:0]
		^ k2[oakt_pkg::MIX_SHIFT +: oakt_pkg::SLOT_W];

endmodule

/* rtl/oakt_queue.sv */
// oakt_queue: short fifo of classified operations between front and back
// uses oakt_pkg
module oakt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  oakt_pkg::q_entry_t din,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output oakt_pkg::q_entry_t dout
);

	oakt_pkg::q_entry_t           ent_q [oakt_pkg::QDEPTH];
	logic [oakt_pkg::QPTR_W-1:0]  wr_q;
	logic [oakt_pkg::QPTR_W-1:0]  rd_q;
	logic [oakt_pkg::QPTR_W:0]    cnt_q;

	assign full  = cnt_q == (oakt_pkg::QPTR_W + 1)'(oakt_pkg::QDEPTH);
	assign valid = cnt_q != '0;
	assign dout  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= din;
		end
	end

endmodule

/* rtl/oakt_back.sv */
// oakt_back: probe sequencer over the slot ram, clear sweep and result register
// uses oakt_pkg; drives the oakt_ram ports from the top level
module oakt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          store_values,
	input  logic                          q_valid,
	input  oakt_pkg::q_entry_t            q_entry,
	output logic                          q_pop,
	output logic                          init_busy,
	output logic                          ram_we,
	output logic [oakt_pkg::SLOT_W-1:0]   ram_waddr,
	output logic [oakt_pkg::ENTRY_W-1:0]  ram_wdata,
	output logic [oakt_pkg::SLOT_W-1:0]   ram_raddr,
	input  logic [oakt_pkg::ENTRY_W-1:0]  ram_rdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// found[0], inserted[1], value_out[9:2], entry_count[20:10], status[22:21], zero pad
	output logic [oakt_pkg::OUT_W-1:0]    m_tdata
);

	localparam logic [oakt_pkg::SLOT_W-1:0] SLOT_LAST = oakt_pkg::SLOT_W'(oakt_pkg::SLOTS - 1);
	localparam logic [oakt_pkg::CNT_W-1:0]  FULL_CNT  = oakt_pkg::CNT_W'(oakt_pkg::FULL_AT);

	oakt_pkg::bk_state_t             state_q, state_d;
	logic [oakt_pkg::SLOT_W-1:0]     addr_q, addr_d;
	logic [oakt_pkg::SLOT_W-1:0]     nprobe_q, nprobe_d;
	oakt_pkg::q_entry_t              op_q, op_d;
	logic [oakt_pkg::CNT_W-1:0]      count_q, count_d;
	oakt_pkg::result_t               res_q, res_d;
	logic                            load_out;

	logic                            m_valid_q;
	oakt_pkg::result_t               out_res_q;
	logic [oakt_pkg::CNT_W-1:0]      out_cnt_q;

	logic [oakt_pkg::KEY_W-1:0]      rd_key;
	logic [oakt_pkg::VAL_W-1:0]      rd_val;
	logic                            hit;
	logic                            empty;
	logic                            is_ins;

	assign rd_key    = ram_rdata[oakt_pkg::KEY_W-1:0];
	assign rd_val    = ram_rdata[oakt_pkg::ENTRY_W-1:oakt_pkg::KEY_W];
	assign hit       = rd_key == op_q.key;
	assign empty     = rd_key == '0;
	assign is_ins    = op_q.kind == oakt_pkg::OP_INSERT;
	assign init_busy = state_q == oakt_pkg::BK_INIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= oakt_pkg::BK_INIT;
			addr_q   <= '0;
			nprobe_q <= '0;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			addr_q   <= addr_d;
			nprobe_q <= nprobe_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		nprobe_d  = nprobe_q;
		op_d      = op_q;
		count_d   = count_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			oakt_pkg::BK_INIT: begin
				ram_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == SLOT_LAST) begin
					state_d = oakt_pkg::BK_IDLE;
				end
			end
			oakt_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					op_d  = q_entry;
					res_d = '0;
					case (q_entry.kind)
						oakt_pkg::OP_CLEAR: begin
							addr_d  = '0;
							state_d = oakt_pkg::BK_CLEAR;
						end
						oakt_pkg::OP_INSERT, oakt_pkg::OP_LOOKUP: begin
							ram_raddr = q_entry.home;
							addr_d    = q_entry.home;
							nprobe_d  = '0;
							state_d   = oakt_pkg::BK_PROBE;
						end
						oakt_pkg::OP_BADKEY: begin
							res_d.status = oakt_pkg::STAT_BADKEY;
							state_d      = oakt_pkg::BK_DONE;
						end
						default: begin
							state_d = oakt_pkg::BK_DONE;
						end
					endcase
				end
			end
			oakt_pkg::BK_CLEAR: begin
				ram_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == SLOT_LAST) begin
					count_d = '0;
					state_d = oakt_pkg::BK_DONE;
				end
			end
			oakt_pkg::BK_PROBE: begin
				ram_wdata = {op_q.value, op_q.key};
				if (hit) begin
					res_d.found = 1'b1;
					if (is_ins) begin
						ram_we = 1'b1;
					end else if (store_values) begin
						res_d.value_out = rd_val;
					end
					state_d = oakt_pkg::BK_DONE;
				end else if (empty) begin
					if (is_ins) begin
						if (count_q >= FULL_CNT) begin
							res_d.status = oakt_pkg::STAT_FULL;
						end else begin
							ram_we         = 1'b1;
							count_d        = count_q + 1'b1;
							res_d.inserted = 1'b1;
						end
					end
					state_d = oakt_pkg::BK_DONE;
				end else if (nprobe_q == SLOT_LAST) begin
					// walked the whole table without a match or a free slot
					if (is_ins) begin
						res_d.status = oakt_pkg::STAT_FULL;
					end
					state_d = oakt_pkg::BK_DONE;
				end else begin
					addr_d    = addr_q + 1'b1;
					ram_raddr = addr_q + 1'b1;
					nprobe_d  = nprobe_q + 1'b1;
				end
			end
			oakt_pkg::BK_DONE: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = oakt_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = oakt_pkg::BK_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			m_valid_q <= load_out | (m_valid_q & ~m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_res_q <= res_q;
			out_cnt_q <= count_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, out_res_q.status, out_cnt_q, out_res_q.value_out,
		out_res_q.inserted, out_res_q.found};

endmodule

/* rtl/open_addressed_key_table.sv */
// open_addressed_key_table: hash table of 64-bit keys, linear probing, 8-bit values
// depends on oakt_pkg, oakt_front, oakt_queue, oakt_back, oakt_ram
// path: front stages s1 and s2, the queue, dispatch in BK_IDLE, one probe per cycle in BK_PROBE,
//   BK_DONE, then the output register; the back end takes the next word from the queue only when
//   it is back in BK_IDLE, a clear word sweeps every slot, and the single read port of the slot ram sets the probe rate
// reset: asynchronous, then a sweep over all SLOTS slots zeroes the slot ram with s_tready low
module open_addressed_key_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [oakt_pkg::IN_W-1:0]    s_tdata, // cmd[1:0], key[65:2], value[73:66], zero pad
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// found[0], inserted[1], value_out[9:2], entry_count[20:10], status[22:21], zero pad
	output logic [oakt_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata
);

	logic                          store_values_q;
	logic                          init_busy;
	logic                          q_full;
	logic                          q_push;
	logic                          q_pop;
	logic                          q_valid;
	oakt_pkg::q_entry_t            q_in;
	oakt_pkg::q_entry_t            q_out;
	logic                          ram_we;
	logic [oakt_pkg::SLOT_W-1:0]   ram_waddr;
	logic [oakt_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [oakt_pkg::SLOT_W-1:0]   ram_raddr;
	logic [oakt_pkg::ENTRY_W-1:0]  ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_values_q <= 1'b1;
		end else if (cfg_we) begin
			store_values_q <= cfg_wdata;
		end
	end

	oakt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_busy (init_busy),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_in)
	);

	oakt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_out)
	);

	oakt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.store_values (store_values_q),
		.q_valid      (q_valid),
		.q_entry      (q_out),
		.q_pop        (q_pop),
		.init_busy    (init_busy),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

	oakt_ram #(
		.WIDTH (oakt_pkg::ENTRY_W),
		.DEPTH (oakt_pkg::SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/oakt_checker.sv */
// oakt_checker: port-level assertions for open_addressed_key_table
// depends on oakt_pkg; bound to the top level below
module oakt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [oakt_pkg::OUT_W-1:0] m_tdata
);

	logic                         found;
	logic                         inserted;
	logic [oakt_pkg::VAL_W-1:0]   value_out;
	logic [oakt_pkg::CNT_W-1:0]   entry_count;
	logic [1:0]                   status;

	assign found       = m_tdata[0];
	assign inserted    = m_tdata[1];
	assign value_out   = m_tdata[9:2];
	assign entry_count = m_tdata[20:10];
	assign status      = m_tdata[22:21];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(found && inserted)
			&& (!inserted || status == 2'(oakt_pkg::STAT_OK)))
		else $error("found and inserted conflict");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && value_out != '0 |-> found && !inserted
			&& status == 2'(oakt_pkg::STAT_OK))
		else $error("value reported without a hit");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> entry_count <= oakt_pkg::CNT_W'(oakt_pkg::FULL_AT))
		else $error("entry count above load limit");

endmodule

bind open_addressed_key_table oakt_checker u_oakt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
